/* design/i2cm_pkg.sv */
// Package for the I2C master byte engine: sequencer state codes and the
// item structs passed between the top level and the sequencer. No dependencies.
package i2cm_pkg;

  localparam int unsigned PhaseW    = 8;
  localparam int unsigned AddrW     = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitCntW   = 4;
  localparam logic [PhaseW-1:0] PhaseTicksRst = 8'd1;

  typedef enum logic [3:0] {
    StIdle    = 4'd0,
    StStart   = 4'd1,
    StTxLo    = 4'd2,
    StTxHi    = 4'd3,
    StSackLo  = 4'd4,
    StSackHi  = 4'd5,
    StRxLo    = 4'd6,
    StRxHi    = 4'd7,
    StMackLo  = 4'd8,
    StMackHi  = 4'd9,
    StStopLo  = 4'd10,
    StStopHi  = 4'd11,
    StStopEnd = 4'd12
  } state_e;

  typedef struct packed {
    logic             start_request;
    logic [AddrW-1:0] slave_address;
    logic             read_mode;
    logic [ByteW-1:0] byte_count;
    logic [ByteW-1:0] write_data;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_release;
    logic             write_request;
    logic [ByteW-1:0] read_byte;
    logic             read_valid;
    logic             busy_res;
    logic             done_res;
    logic             ack_error;
  } out_item_t;

endpackage

/* design/i2cm_seq.sv */
// Bit/phase sequencer of the I2C master: state registers, next-state logic
// and per-tick result logic. Depends on i2cm_pkg.
module i2cm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [i2cm_pkg::PhaseW-1:0] phase_ticks_i,
  input  i2cm_pkg::in_item_t          item_i,
  output i2cm_pkg::out_item_t         res_o
);

  i2cm_pkg::state_e state_q, state_d;
  logic [i2cm_pkg::BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [i2cm_pkg::ByteW-1:0]   bytes_left_q, bytes_left_d;
  logic [i2cm_pkg::ByteW-1:0]   shift_q, shift_d;
  logic [i2cm_pkg::ByteW-1:0]   addr_dir_q, addr_dir_d;
  logic                         err_q, err_d;
  logic [i2cm_pkg::PhaseW-1:0]  tick_q, tick_d;

  logic [i2cm_pkg::PhaseW-1:0]  phase_len;
  logic                         phase_end;
  logic [i2cm_pkg::BitCntW-1:0] bit_cnt_inc;
  logic                         last_bit;

  // zero phase length behaves as one tick
  assign phase_len   = (phase_ticks_i == '0) ? i2cm_pkg::PhaseW'(1) : phase_ticks_i;
  assign phase_end   = ({1'b0, tick_q} + 9'd1) >= {1'b0, phase_len};
  assign bit_cnt_inc = bit_cnt_q + 4'd1;
  assign last_bit    = bit_cnt_inc >= 4'd8;

  always_comb begin
    state_d      = state_q;
    bit_cnt_d    = bit_cnt_q;
    bytes_left_d = bytes_left_q;
    shift_d      = shift_q;
    addr_dir_d   = addr_dir_q;
    err_d        = err_q;
    tick_d       = tick_q;
    unique case (state_q)
      i2cm_pkg::StIdle: begin
        if (item_i.start_request) begin
          addr_dir_d   = {item_i.slave_address, item_i.read_mode};
          shift_d      = {item_i.slave_address, item_i.read_mode};
          bytes_left_d = item_i.byte_count;
          err_d        = 1'b0;
          bit_cnt_d    = '0;
          tick_d       = '0;
          state_d      = i2cm_pkg::StStart;
        end
      end
      default: begin
        if (!phase_end) begin
          tick_d = tick_q + 8'd1;
        end else begin
          tick_d = '0;
          unique case (state_q)
            i2cm_pkg::StStart:  state_d = i2cm_pkg::StTxLo;
            i2cm_pkg::StTxLo:   state_d = i2cm_pkg::StTxHi;
            i2cm_pkg::StTxHi: begin
              shift_d = {shift_q[6:0], 1'b0};
              if (last_bit) begin
                bit_cnt_d = '0;
                state_d   = i2cm_pkg::StSackLo;
              end else begin
                bit_cnt_d = bit_cnt_inc;
                state_d   = i2cm_pkg::StTxLo;
              end
            end
            i2cm_pkg::StSackLo: state_d = i2cm_pkg::StSackHi;
            i2cm_pkg::StSackHi: begin
              err_d     = err_q | item_i.sda_in;
              bit_cnt_d = '0;
              if (bytes_left_q == '0) begin
                state_d = i2cm_pkg::StStopLo;
              end else if (addr_dir_q[0]) begin
                shift_d = '0;
                state_d = i2cm_pkg::StRxLo;
              end else begin
                shift_d      = item_i.write_data;
                bytes_left_d = bytes_left_q - 8'd1;
                state_d      = i2cm_pkg::StTxLo;
              end
            end
            i2cm_pkg::StRxLo:   state_d = i2cm_pkg::StRxHi;
            i2cm_pkg::StRxHi: begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              if (last_bit) begin
                bit_cnt_d    = '0;
                bytes_left_d = bytes_left_q - 8'd1;
                state_d      = i2cm_pkg::StMackLo;
              end else begin
                bit_cnt_d = bit_cnt_inc;
                state_d   = i2cm_pkg::StRxLo;
              end
            end
            i2cm_pkg::StMackLo: state_d = i2cm_pkg::StMackHi;
            i2cm_pkg::StMackHi: begin
              if (bytes_left_q == '0) begin
                state_d = i2cm_pkg::StStopLo;
              end else begin
                shift_d = '0;
                state_d = i2cm_pkg::StRxLo;
              end
            end
            i2cm_pkg::StStopLo: state_d = i2cm_pkg::StStopHi;
            i2cm_pkg::StStopHi: state_d = i2cm_pkg::StStopEnd;
            default:            state_d = i2cm_pkg::StIdle;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    res_o.scl_level   = 1'b1;
    res_o.sda_release = 1'b1;
    unique case (state_q)
      i2cm_pkg::StStart:  res_o.sda_release = 1'b0;
      i2cm_pkg::StTxLo: begin
        res_o.scl_level   = 1'b0;
        res_o.sda_release = shift_q[7];
      end
      i2cm_pkg::StTxHi:   res_o.sda_release = shift_q[7];
      i2cm_pkg::StSackLo: res_o.scl_level = 1'b0;
      i2cm_pkg::StRxLo:   res_o.scl_level = 1'b0;
      // NACK only after the last read byte
      i2cm_pkg::StMackLo: begin
        res_o.scl_level   = 1'b0;
        res_o.sda_release = (bytes_left_q == '0);
      end
      i2cm_pkg::StMackHi: res_o.sda_release = (bytes_left_q == '0);
      i2cm_pkg::StStopLo: begin
        res_o.scl_level   = 1'b0;
        res_o.sda_release = 1'b0;
      end
      i2cm_pkg::StStopHi: res_o.sda_release = 1'b0;
      default: ;
    endcase
    res_o.busy_res      = (state_q != i2cm_pkg::StIdle) || item_i.start_request;
    res_o.write_request = (state_q == i2cm_pkg::StSackHi) && phase_end &&
                          (bytes_left_q != '0) && !addr_dir_q[0];
    res_o.read_valid    = (state_q == i2cm_pkg::StRxHi) && phase_end && last_bit;
    res_o.read_byte     = res_o.read_valid ? {shift_q[6:0], item_i.sda_in} : '0;
    res_o.done_res      = (state_q == i2cm_pkg::StStopEnd) && phase_end;
    res_o.ack_error     = res_o.done_res & err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= i2cm_pkg::StIdle;
      bit_cnt_q    <= '0;
      bytes_left_q <= '0;
      shift_q      <= '0;
      addr_dir_q   <= '0;
      err_q        <= 1'b0;
      tick_q       <= '0;
    end else if (step_i) begin
      state_q      <= state_d;
      bit_cnt_q    <= bit_cnt_d;
      bytes_left_q <= bytes_left_d;
      shift_q      <= shift_d;
      addr_dir_q   <= addr_dir_d;
      err_q        <= err_d;
      tick_q       <= tick_d;
    end
  end

endmodule

/* design/i2c_master_byte_engine.sv */
// Top level of the I2C master byte engine: input register, phase-length
// register, result register. Depends on i2cm_pkg and i2cm_seq.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o   | one bus tick of inputs
//   out     | output    | out_valid_o / out_ready_i | line levels and status
//   cfg     | input     | cfg_we_i, no wait         | phase_ticks
//
// One tick per cycle while the result is not stalled; a tick passes the input
// register, then the sequencer step that loads the result register.
// Reset clears the valid flags and the sequencer to idle, phase_ticks to 1.
// A stalled result holds; one more tick waits in the input register and
// in_ready_o drops until the result is taken.
module i2c_master_byte_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_request_i,
  input  logic [6:0] slave_address_i,
  input  logic       read_mode_i,
  input  logic [7:0] byte_count_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_release_o,
  output logic       write_request_o,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       ack_error_o
);

  logic                        in_vld_q;
  i2cm_pkg::in_item_t          in_item_q;
  logic                        out_vld_q;
  i2cm_pkg::out_item_t         out_item_q, res;
  logic [i2cm_pkg::PhaseW-1:0] phase_ticks_q;
  logic                        step, accept;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cm_pkg::PhaseTicksRst;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= '{start_request: start_request_i, slave_address: slave_address_i,
                     read_mode: read_mode_i, byte_count: byte_count_i,
                     write_data: write_data_i, sda_in: sda_in_i};
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .phase_ticks_i (phase_ticks_q),
    .item_i        (in_item_q),
    .res_o         (res)
  );

  assign out_valid_o     = out_vld_q;
  assign scl_level_o     = out_item_q.scl_level;
  assign sda_release_o   = out_item_q.sda_release;
  assign write_request_o = out_item_q.write_request;
  assign read_byte_o     = out_item_q.read_byte;
  assign read_valid_o    = out_item_q.read_valid;
  assign busy_res_o      = out_item_q.busy_res;
  assign done_res_o      = out_item_q.done_res;
  assign ack_error_o     = out_item_q.ack_error;

  a_err_only_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_error_o |-> done_res_o)
    else $error("ack_error outside done");

  a_rbyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_byte_o == 8'd0)
    else $error("read_byte nonzero without read_valid");

  a_wr_rd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_request_o && read_valid_o))
    else $error("write_request and read_valid together");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o && scl_level_o && sda_release_o)
    else $error("done without busy and released lines");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule
